FILE: rtl/core/lzwd_pkg.sv
package lzwd_pkg;

  // Field widths of the stream payload
  localparam int unsigned CODE_IN_W = 12;
  localparam int unsigned BYTE_W    = 8;

  // Codes below this value are single-byte literals
  localparam int unsigned LIT_COUNT = 256;

  // in_tuser: what the transfer asks for
  localparam logic ACT_CODE = 1'b0;
  localparam logic ACT_PULL = 1'b1;

  // out_tuser: result kind
  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_END      = 2'd1,
    KIND_REJECT   = 2'd2,
    KIND_TOO_LONG = 2'd3
  } kind_t;

  // Controller -> datapath
  typedef struct packed {
    logic pop;         // pull: drop count, read top of stack
    logic reject;      // stage a reject result
    logic first;       // first code: push its low byte as a literal
    logic fin;         // end code: mark finished, stage end result
    logic walk_start;  // begin a chain walk, issue first table read
    logic kwkwk;       // with walk_start: code not yet defined
    logic push;        // one walk step: push a byte, follow prefix
    logic done;        // last walk step: add dictionary entry
    logic abort;       // stack overflow: drop stack, stage error
    logic emit;        // move staged result into output register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic cnt_zero;    // nothing pending on the stack
    logic cnt_full;    // stack holds its full depth
    logic finished;    // end code seen
    logic seen;        // first code taken
    logic code_end;    // incoming code is all ones
    logic code_undef;  // incoming code not yet in the dictionary
    logic literal;     // walk reached a code below 256
    logic out_room;    // output register can take a result
  } sts_t;

endpackage

FILE: rtl/core/lzwd_ctrl.sv
module lzwd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic            in_action,
  output logic            in_tready,
  input  lzwd_pkg::sts_t  sts,
  output lzwd_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_action == lzwd_pkg::ACT_PULL) begin
            if (!sts.cnt_zero) begin
              cmd.pop   = 1'b1;
              state_nxt = ST_EMIT;
            end
          end else if (sts.finished || !sts.cnt_zero) begin
            cmd.reject = 1'b1;
            state_nxt  = ST_EMIT;
          end else if (!sts.seen) begin
            cmd.first = 1'b1;
          end else if (sts.code_end) begin
            cmd.fin   = 1'b1;
            state_nxt = ST_EMIT;
          end else begin
            cmd.walk_start = 1'b1;
            cmd.kwkwk      = sts.code_undef;
            state_nxt      = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (sts.cnt_full) begin
          cmd.abort = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          cmd.push = 1'b1;
          if (sts.literal) begin
            cmd.done  = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        if (sts.out_room) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/lzwd_dpath.sv
module lzwd_dpath #(
  parameter int unsigned CODE_BITS   = 12,
  parameter int unsigned STACK_DEPTH = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [lzwd_pkg::CODE_IN_W-1:0] in_code,
  input  lzwd_pkg::cmd_t                 cmd,
  output lzwd_pkg::sts_t                 sts,
  input  logic                           out_tready,
  output logic                           out_tvalid,
  output logic [1:0]                     out_kind,
  output logic [lzwd_pkg::BYTE_W-1:0]    out_byte,
  output logic                           out_last
);

  localparam int unsigned TBL_DEPTH = 1 << CODE_BITS;
  localparam int unsigned SAW       = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W     = SAW + 1;
  localparam int unsigned BW        = lzwd_pkg::BYTE_W;
  localparam logic [CODE_BITS-1:0] ALL_ONES   = {CODE_BITS{1'b1}};
  localparam logic [CODE_BITS-1:0] FIRST_FREE = CODE_BITS'(lzwd_pkg::LIT_COUNT);

  // Dictionary and reverse stack
  logic [CODE_BITS-1:0] pref_mem [TBL_DEPTH];
  logic [BW-1:0]        suf_mem  [TBL_DEPTH];
  logic [BW-1:0]        stk_mem  [STACK_DEPTH];

  logic [CODE_BITS-1:0] pref_rd_r, cur_r, hold_r, prev_r, nf_r;
  logic [BW-1:0]        suf_rd_r, stk_rd_r, fbl_r;
  logic                 hit_r, seen_r, fin_r;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  lzwd_pkg::kind_t      res_kind_r;
  logic                 res_last_r;
  logic                 out_valid_r, out_last_r;
  lzwd_pkg::kind_t      out_kind_r;
  logic [BW-1:0]        out_byte_r;

  logic [CODE_BITS-1:0] code_c, rd_addr, pref_eff;
  logic [BW-1:0]        suf_eff, push_byte, stk_wr_data;
  logic                 literal, stk_wr_en, out_room;
  logic [CNT_W-1:0]     pop_cnt;

  assign code_c = CODE_BITS'(in_code);

  // Entries at or above the fill mark were never written and read as zero
  assign pref_eff  = hit_r ? pref_rd_r : '0;
  assign suf_eff   = hit_r ? suf_rd_r  : '0;
  assign literal   = (cur_r[CODE_BITS-1:BW] == '0);
  assign push_byte = literal ? cur_r[BW-1:0] : suf_eff;
  assign rd_addr   = cmd.walk_start ? (cmd.kwkwk ? prev_r : code_c) : pref_eff;
  assign pop_cnt   = cnt_r - CNT_W'(1);

  assign stk_wr_en   = cmd.first | (cmd.walk_start & cmd.kwkwk) | cmd.push;
  assign stk_wr_data = cmd.first ? code_c[BW-1:0] : (cmd.push ? push_byte : fbl_r);

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.pop) begin
      cnt_nxt = pop_cnt;
    end else if (cmd.abort) begin
      cnt_nxt = '0;
    end else if (stk_wr_en) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  // Table port: read every cycle, write a new entry at the end of a walk
  always_ff @(posedge clk) begin
    pref_rd_r <= pref_mem[rd_addr];
    suf_rd_r  <= suf_mem[rd_addr];
    hit_r     <= (rd_addr < nf_r);
    if (cmd.done && (nf_r != ALL_ONES)) begin
      pref_mem[nf_r] <= prev_r;
      suf_mem[nf_r]  <= cur_r[BW-1:0];
    end
  end

  // Stack: push at the count, pop reads below it
  always_ff @(posedge clk) begin
    if (stk_wr_en) begin
      stk_mem[cnt_r[SAW-1:0]] <= stk_wr_data;
    end
    if (cmd.pop) begin
      stk_rd_r <= stk_mem[pop_cnt[SAW-1:0]];
    end
  end

  // Walk registers (payload)
  always_ff @(posedge clk) begin
    if (cmd.walk_start || cmd.push) begin
      cur_r <= rd_addr;
    end
    if (cmd.walk_start) begin
      hold_r <= code_c;
    end
  end

  // Decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      nf_r   <= FIRST_FREE;
      prev_r <= '0;
      fbl_r  <= '0;
      seen_r <= 1'b0;
      fin_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.first) begin
        seen_r <= 1'b1;
        prev_r <= code_c;
        fbl_r  <= code_c[BW-1:0];
      end
      if (cmd.fin) begin
        fin_r <= 1'b1;
      end
      if (cmd.done) begin
        prev_r <= hold_r;
        fbl_r  <= cur_r[BW-1:0];
        if (nf_r != ALL_ONES) begin
          nf_r <= nf_r + CODE_BITS'(1);
        end
      end
    end
  end

  // Staged result
  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      res_kind_r <= lzwd_pkg::KIND_BYTE;
      res_last_r <= (cnt_r == CNT_W'(1));
    end else if (cmd.reject) begin
      res_kind_r <= lzwd_pkg::KIND_REJECT;
      res_last_r <= 1'b0;
    end else if (cmd.fin) begin
      res_kind_r <= lzwd_pkg::KIND_END;
      res_last_r <= 1'b0;
    end else if (cmd.abort) begin
      res_kind_r <= lzwd_pkg::KIND_TOO_LONG;
      res_last_r <= 1'b0;
    end
  end

  // Output register
  assign out_room = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r <= res_kind_r;
      out_byte_r <= (res_kind_r == lzwd_pkg::KIND_BYTE) ? stk_rd_r : '0;
      out_last_r <= res_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_byte   = out_byte_r;
  assign out_last   = out_last_r;

  assign sts.cnt_zero   = (cnt_r == '0);
  assign sts.cnt_full   = (cnt_r == CNT_W'(STACK_DEPTH));
  assign sts.finished   = fin_r;
  assign sts.seen       = seen_r;
  assign sts.code_end   = (code_c == ALL_ONES);
  assign sts.code_undef = (code_c >= nf_r);
  assign sts.literal    = literal;
  assign sts.out_room   = out_room;

endmodule

FILE: rtl/core/lzw_fixed_width_decoder_top.sv
// Channel  Dir  tdata               tuser            tlast
// in_      in   [11:0] code         [0] action       -
// out_     out  [7:0]  byte_res     [1:0] kind       last byte of string
//
// Code: accepted, then walked with one table read per chain step; the
//   repeated first byte of a not-yet-defined code is pushed in the accept cycle.
// Pull, reject, end code: staged, then loaded into the output register; a stack
//   overrun ends its walk the same way. First code: pushed as a literal, no result.
// rst_n synchronous; table entries at or above the next free code read as 0.
// in_tready low during a walk and while a staged result waits for out_ room.
module lzw_fixed_width_decoder_top #(
  parameter int unsigned CODE_BITS   = 12,
  parameter int unsigned STACK_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [11:0] code, [15:12] zero
  input  logic [0:0]  in_tuser,   // [0] action: 0 code, 1 pull
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] byte_res
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // last
);

  lzwd_pkg::cmd_t cmd;
  lzwd_pkg::sts_t sts;

  // Sequencing: idle / chain walk / result hand-off
  lzwd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_action (in_tuser[0]),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Dictionary, reverse stack, decoder state and output register
  lzwd_dpath #(
    .CODE_BITS   (CODE_BITS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_code    (in_tdata[lzwd_pkg::CODE_IN_W-1:0]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_kind   (out_tuser),
    .out_byte   (out_tdata),
    .out_last   (out_tlast)
  );

  // A walk step always leaves something on the stack
  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |=> !sts.cnt_zero)
    else $error("stack empty after push");

  // Overflow drops the partial string
  a_abort_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.abort |=> sts.cnt_zero)
    else $error("stack not cleared after overflow");

  // A staged result never overwrites one still waiting downstream
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_room)
    else $error("result loaded into a full output register");

  // Finishing a walk returns to accepting input
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.done |=> in_tready)
    else $error("not idle after walk end");

  // A pull with bytes pending drops in_tready next, while its byte result is staged
  a_pull_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser[0] == lzwd_pkg::ACT_PULL) && !sts.cnt_zero)
      |=> !in_tready)
    else $error("pull with pending bytes produced no result");

endmodule

FILE: bench/tb_lzw_fixed_width_decoder_top.sv
module tb_lzw_fixed_width_decoder_top;

  typedef logic [lzwd_pkg::CODE_IN_W-1:0] code_t;

  // Dictionary geometry at the default build of the block
  localparam int unsigned DICT_DEPTH  = 1 << lzwd_pkg::CODE_IN_W;
  localparam int unsigned STACK_DEPTH = 4096;
  localparam code_t       END_CODE    = '1;             // all ones ends the data
  localparam int unsigned LAST_DEF    = DICT_DEPTH - 2; // highest code ever defined

  // Run shape
  localparam int PLAN_ROWS   = 20;
  localparam int MAIN_END    = 1030;    // input transfers before the closing steps
  localparam int HOLD_CYCLES = 400;     // long out_tready hold-off
  localparam int TAIL_CYCLES = STACK_DEPTH + 64;
  localparam int CYCLE_LIMIT = 1000000;

  // One result transfer: kind in tuser, byte in tdata, end of string in tlast
  typedef struct packed {
    lzwd_pkg::kind_t kind;
    logic [7:0]      byte_val;
    logic            last;
  } result_t;

  // Directed step: the result is typed in only when typed is set
  typedef struct packed {
    logic            act;
    code_t           code;
    bit              typed;
    lzwd_pkg::kind_t kind;
    logic [7:0]      byte_val;
    logic            last;
  } plan_row_t;

  localparam result_t NO_RESULT = '0;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic [0:0]  in_tuser   = lzwd_pkg::ACT_CODE;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  always #6 clk = ~clk;

  lzw_fixed_width_decoder_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // ---------------------------------------------------------------------------
  // Decoder shadow: dictionary, reverse byte stack and walk state
  // ---------------------------------------------------------------------------
  code_t       dict_prefix [DICT_DEPTH];
  logic [7:0]  dict_suffix [DICT_DEPTH];
  logic [7:0]  byte_stack  [STACK_DEPTH];
  int unsigned stack_fill;
  int unsigned free_code;
  code_t       last_code;
  logic [7:0]  last_head;   // first byte of the previous string
  bit          got_first;
  bit          ended;

  // Decoded results still owed by the block, oldest first
  result_t decoded_fifo [$];

  int  fed;            // accepted input transfers
  int  outs_seen;      // accepted output transfers
  int  kind_seen [4];
  int  errors;
  int  cycles;
  bit  calm;           // stretch with no idling on either side
  bit  hold_done;

  always @(posedge clk) cycles <= cycles + 1;

  // Push the string of a code, last byte first; 0 on stack overflow
  // (a cyclic prefix chain ends up here too).
  function automatic bit walk_chain(input code_t start);
    code_t c;
    c = start;
    while (c >= lzwd_pkg::LIT_COUNT) begin
      if (stack_fill >= STACK_DEPTH) return 1'b0;
      byte_stack[stack_fill] = dict_suffix[c];
      stack_fill++;
      c = dict_prefix[c];
    end
    if (stack_fill >= STACK_DEPTH) return 1'b0;
    byte_stack[stack_fill] = c[7:0];
    stack_fill++;
    return 1'b1;
  endfunction

  // Advance the shadow by one input transfer; 1 when it yields a result
  function automatic bit decode_step(input logic act, input code_t code,
                                     output result_t r);
    logic [7:0] head;
    bit         ok;
    r = NO_RESULT;
    if (act == lzwd_pkg::ACT_PULL) begin
      if (stack_fill == 0) return 1'b0;
      stack_fill--;
      r.kind     = lzwd_pkg::KIND_BYTE;
      r.byte_val = byte_stack[stack_fill];
      r.last     = (stack_fill == 0);
      return 1'b1;
    end
    if (ended || stack_fill != 0) begin
      r.kind = lzwd_pkg::KIND_REJECT;
      return 1'b1;
    end
    if (!got_first) begin
      // first code is a literal, never the end code
      got_first     = 1'b1;
      last_code     = code;
      last_head     = code[7:0];
      byte_stack[0] = code[7:0];
      stack_fill    = 1;
      return 1'b0;
    end
    if (code == END_CODE) begin
      ended  = 1'b1;
      r.kind = lzwd_pkg::KIND_END;
      return 1'b1;
    end
    if (code >= free_code) begin
      // not yet defined: previous string plus its own first byte
      byte_stack[0] = last_head;
      stack_fill    = 1;
      ok = walk_chain(last_code);
    end else begin
      ok = walk_chain(code);
    end
    if (!ok) begin
      stack_fill = 0;
      r.kind     = lzwd_pkg::KIND_TOO_LONG;
      return 1'b1;
    end
    head = byte_stack[stack_fill-1];
    if (free_code <= LAST_DEF) begin
      dict_prefix[free_code] = last_code;
      dict_suffix[free_code] = head;
      free_code++;
    end
    last_code = code;
    last_head = head;
    return 1'b0;
  endfunction

  // Any code word, for pulls and for codes sent while bytes are pending
  function automatic code_t any_code();
    return code_t'($urandom_range(DICT_DEPTH-1));
  endfunction

  // Code choice with nothing pending: literals, defined codes, the
  // not-yet-defined code and codes above it.
  function automatic code_t pick_code();
    int unsigned r;
    int unsigned v;
    r = $urandom_range(99);
    if (r < 45) begin
      v = $urandom_range(lzwd_pkg::LIT_COUNT-1);
    end else if (r < 75 && free_code > lzwd_pkg::LIT_COUNT) begin
      v = $urandom_range(free_code-1, lzwd_pkg::LIT_COUNT);
    end else if (r < 87 && free_code <= LAST_DEF) begin
      v = free_code;
    end else if (r < 93 && free_code < LAST_DEF) begin
      v = $urandom_range(LAST_DEF, free_code+1);
    end else begin
      v = $urandom_range(lzwd_pkg::LIT_COUNT-1);
    end
    return code_t'(v);
  endfunction

  task automatic flag_mismatch(input string what);
    errors++;
    if (errors <= 40) $display("[cycle %0d] mismatch: %s", cycles, what);
  endtask

  // One input transfer. An idle gap may come first. The shadow is stepped
  // at the accepting edge, so the expectation is queued before the result
  // can show up on the out_ side.
  task automatic send_item(input logic act, input code_t code,
                           input bit typed, input result_t want);
    result_t got;
    bit      has;
    if (!calm && $urandom_range(99) < 12) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {4'b0000, code};
    do @(posedge clk); while (in_tready !== 1'b1);
    fed++;
    has = decode_step(act, code, got);
    if (typed) decoded_fifo.push_back(want);
    else if (has) decoded_fifo.push_back(got);
  endtask

  // Sender goes quiet until every owed result has been taken
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (decoded_fifo.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. Reading of the rows:
  //  - pull with nothing pending, then an all-ones first code (a literal, so
  //    its low byte 8'hFF is what comes out)
  //  - code while that byte is still pending: rejected
  //  - code one above the next free code (undefined, above), then a literal
  //    that defines that code with itself as prefix: a self loop
  //  - that code again: the walk overruns the stack, nothing left to pull
  //  - code equal to the next free code (undefined), then plain literals
  // ---------------------------------------------------------------------------
  plan_row_t plan [PLAN_ROWS];

  initial begin
    plan[0]  = '{lzwd_pkg::ACT_PULL, 12'h000, 1'b0, lzwd_pkg::KIND_BYTE,     8'h00, 1'b0};
    plan[1]  = '{lzwd_pkg::ACT_CODE, 12'hFFF, 1'b0, lzwd_pkg::KIND_BYTE,     8'h00, 1'b0};
    plan[2]  = '{lzwd_pkg::ACT_CODE, 12'h123, 1'b1, lzwd_pkg::KIND_REJECT,   8'h00, 1'b0};
    plan[3]  = '{lzwd_pkg::ACT_PULL, 12'hFFF, 1'b1, lzwd_pkg::KIND_BYTE,     8'hFF, 1'b1};
    plan[4]  = '{lzwd_pkg::ACT_PULL, 12'h000, 1'b0, lzwd_pkg::KIND_BYTE,     8'h00, 1'b0};
    plan[5]  = '{lzwd_pkg::ACT_CODE, 12'h101, 1'b0, lzwd_pkg::KIND_BYTE,     8'h00, 1'b0};
    plan[6]  = '{lzwd_pkg::ACT_PULL, 12'hAAA, 1'b0, lzwd_pkg::KIND_BYTE,     8'h00, 1'b0};
    plan[7]  = '{lzwd_pkg::ACT_PULL, 12'h555, 1'b0, lzwd_pkg::KIND_BYTE,     8'h00, 1'b0};
    plan[8]  = '{lzwd_pkg::ACT_PULL, 12'h000, 1'b0, lzwd_pkg::KIND_BYTE,     8'h00, 1'b0};
    plan[9]  = '{lzwd_pkg::ACT_CODE, 12'h041, 1'b0, lzwd_pkg::KIND_BYTE,     8'h00, 1'b0};
    plan[10] = '{lzwd_pkg::ACT_PULL, 12'h000, 1'b0, lzwd_pkg::KIND_BYTE,     8'h00, 1'b0};
    plan[11] = '{lzwd_pkg::ACT_CODE, 12'h101, 1'b1, lzwd_pkg::KIND_TOO_LONG, 8'h00, 1'b0};
    plan[12] = '{lzwd_pkg::ACT_PULL, 12'h000, 1'b0, lzwd_pkg::KIND_BYTE,     8'h00, 1'b0};
    plan[13] = '{lzwd_pkg::ACT_CODE, 12'h102, 1'b0, lzwd_pkg::KIND_BYTE,     8'h00, 1'b0};
    plan[14] = '{lzwd_pkg::ACT_PULL, 12'h000, 1'b0, lzwd_pkg::KIND_BYTE,     8'h00, 1'b0};
    plan[15] = '{lzwd_pkg::ACT_PULL, 12'h000, 1'b0, lzwd_pkg::KIND_BYTE,     8'h00, 1'b0};
    plan[16] = '{lzwd_pkg::ACT_CODE, 12'h000, 1'b0, lzwd_pkg::KIND_BYTE,     8'h00, 1'b0};
    plan[17] = '{lzwd_pkg::ACT_PULL, 12'h000, 1'b0, lzwd_pkg::KIND_BYTE,     8'h00, 1'b0};
    plan[18] = '{lzwd_pkg::ACT_CODE, 12'h0FF, 1'b0, lzwd_pkg::KIND_BYTE,     8'h00, 1'b0};
    plan[19] = '{lzwd_pkg::ACT_PULL, 12'h000, 1'b0, lzwd_pkg::KIND_BYTE,     8'h00, 1'b0};
  end

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure, one long hold-off once a few dozen
  // results are out (the sender keeps offering, so the block backs up into
  // in_tready), and an in-order compare against the owed results.
  // ---------------------------------------------------------------------------
  initial begin : result_side
    result_t head;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid === 1'b1 && out_tready) begin
        outs_seen++;
        if (!$isunknown(out_tuser)) kind_seen[out_tuser]++;
        if (decoded_fifo.size() == 0) begin
          flag_mismatch($sformatf("unexpected transfer kind=%0d byte=%h last=%b",
                                  out_tuser, out_tdata, out_tlast));
        end else begin
          head = decoded_fifo.pop_front();
          if (out_tuser !== head.kind)
            flag_mismatch($sformatf("kind %0d, want %0d", out_tuser, head.kind));
          if (out_tdata !== head.byte_val)
            flag_mismatch($sformatf("byte %h, want %h", out_tdata, head.byte_val));
          if (out_tlast !== head.last)
            flag_mismatch($sformatf("last %b, want %b", out_tlast, head.last));
        end
      end
      if (!hold_done && outs_seen >= 30) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 12);
      end
    end
  end

  // Watchdog: a hung handshake ends the run here
  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results still owed", cycles,
             decoded_fifo.size());
    $display("FAIL lzw_fixed_width_decoder_top");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    result_t want;
    int      i;

    // shadow reset state
    for (i = 0; i < DICT_DEPTH; i++) begin
      dict_prefix[i] = '0;
      dict_suffix[i] = '0;
    end
    for (i = 0; i < STACK_DEPTH; i++) byte_stack[i] = '0;
    stack_fill = 0;
    free_code  = lzwd_pkg::LIT_COUNT;
    last_code  = '0;
    last_head  = '0;
    got_first  = 1'b0;
    ended      = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows
    for (i = 0; i < PLAN_ROWS; i++) begin
      want.kind     = plan[i].kind;
      want.byte_val = plan[i].byte_val;
      want.last     = plan[i].last;
      send_item(plan[i].act, plan[i].code, plan[i].typed, want);
    end
    wait_drained();

    // Random part. Mostly well-formed: a code, then pulls until its string
    // is out. A few codes land while bytes are pending (rejects) and a few
    // pulls hit an empty stack.
    while (fed < MAIN_END) begin
      calm = (fed >= 350 && fed < 650);
      if (stack_fill != 0) begin
        if ($urandom_range(99) < 6)
          send_item(lzwd_pkg::ACT_CODE, any_code(), 1'b0, NO_RESULT);
        else
          send_item(lzwd_pkg::ACT_PULL, any_code(), 1'b0, NO_RESULT);
      end else if ($urandom_range(99) < 6) begin
        send_item(lzwd_pkg::ACT_PULL, any_code(), 1'b0, NO_RESULT);
      end else begin
        send_item(lzwd_pkg::ACT_CODE, pick_code(), 1'b0, NO_RESULT);
      end
    end
    calm = 1'b0;

    // empty the stack, end the data, then poke the finished block
    while (stack_fill != 0)
      send_item(lzwd_pkg::ACT_PULL, any_code(), 1'b0, NO_RESULT);
    wait_drained();
    send_item(lzwd_pkg::ACT_CODE, END_CODE, 1'b0, NO_RESULT);
    for (i = 0; i < 12; i++)
      send_item(i[0] ? lzwd_pkg::ACT_PULL : lzwd_pkg::ACT_CODE,
                (i == 2) ? END_CODE : any_code(), 1'b0, NO_RESULT);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run: %0d inputs, %0d results (%0d bytes, %0d rejects, %0d overruns, %0d end)",
             fed, outs_seen, kind_seen[lzwd_pkg::KIND_BYTE],
             kind_seen[lzwd_pkg::KIND_REJECT], kind_seen[lzwd_pkg::KIND_TOO_LONG],
             kind_seen[lzwd_pkg::KIND_END]);
    $display("Dictionary grew to code %0d; self-looping chain and undefined codes walked",
             free_code - 1);
    if (errors == 0 && decoded_fifo.size() == 0) begin
      $display("PASS lzw_fixed_width_decoder_top");
    end else begin
      $display("%0d mismatches, %0d results never seen", errors, decoded_fifo.size());
      $display("FAIL lzw_fixed_width_decoder_top");
    end
    $finish;
  end

endmodule
